@@ src/psh_pkg.sv @@
// ----------------------------------------------------------------------------
// psh_pkg: shared types and constants for the plucked-string voice
// Holds the item codes, the controller/datapath interface structs, the
// storage layouts and the quarter-wave sine table built at elaboration.
// ----------------------------------------------------------------------------
package psh_pkg;

   // Voice size and number formats
   localparam int HARMONICS      = 16;
   localparam int PHASE_BITS     = 24;
   localparam int SINE_ADDR_BITS = 10;

   localparam int HARM_IDX_W = (HARMONICS > 1) ? $clog2(HARMONICS) : 1;
   localparam logic [HARM_IDX_W-1:0] LAST_IDX = HARM_IDX_W'(HARMONICS - 1);

   // Coefficient entry {amplitude, step, decay}; voice entry {envelope, phase}
   localparam int COEF_W  = 48 + PHASE_BITS;
   localparam int VOICE_W = 24 + PHASE_BITS;

   // Accumulator holds the sum of 25x16 signed products over all harmonics
   localparam int PROD_W  = 41;
   localparam int ACC_W   = PROD_W + ((HARMONICS > 1) ? $clog2(HARMONICS) : 0);
   localparam int SCALE_W = ACC_W + 2;

   localparam int CSR_DATA_W = 25;
   localparam int CSR_IDX_W  = 1;

   typedef enum logic [1:0] {
      MODE_TICK    = 2'd0,
      MODE_PLUCK   = 2'd1,
      MODE_SILENCE = 2'd2,
      MODE_LOAD    = 2'd3
   } mode_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_ATTACK_STEP   = 1'b0,
      CSR_SILENCE_LEVEL = 1'b1
   } csr_index_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_ISSUE,
      ST_DRAIN,
      ST_SCALE,
      ST_EMIT
   } state_type;

   // Controller to datapath
   typedef struct packed {
      logic                  load;        // write coefficient entry now
      logic                  pluck;       // restart note, sweep follows
      logic                  silence;     // stop note
      logic                  idle_tick;   // tick while silent
      logic                  tick_start;  // ringing tick, sweep follows
      logic                  issue;       // read harmonic at addr
      logic                  issue_tick;  // sweep kind: 1 tick, 0 pluck
      logic [HARM_IDX_W-1:0] addr;
      logic                  scale;       // apply attack gain to the sum
      logic                  emit_tick;   // present the tick sample
   } cmd_type;

   // Datapath to controller
   typedef struct packed {
      logic sounding;
      logic pipe_busy;
   } status_type;

   // Quarter-wave sine table, entries 0 .. QUARTER inclusive
   localparam int QUARTER = 1 << (SINE_ADDR_BITS - 2);
   localparam longint unsigned Q30_ONE    = 64'd1 << 30;
   localparam longint unsigned TWO_PI_Q30 = 64'd6746518852;

   typedef logic [QUARTER:0][14:0] qsine_type;

   // round(32767 * sin(2*pi*j/2^SINE_ADDR_BITS)) from a Q30 odd polynomial
   function automatic logic [14:0] quarter_sine(input int unsigned j);
      longint unsigned x;
      longint unsigned x2;
      longint unsigned t;
      longint unsigned v;
      x  = (longint'(j) * TWO_PI_Q30) >> SINE_ADDR_BITS;
      x2 = (x * x) >> 30;
      t  = Q30_ONE - x2 / 110;
      t  = Q30_ONE - ((x2 * t) >> 30) / 72;
      t  = Q30_ONE - ((x2 * t) >> 30) / 42;
      t  = Q30_ONE - ((x2 * t) >> 30) / 20;
      t  = Q30_ONE - ((x2 * t) >> 30) / 6;
      v  = (((x * t) >> 30) * 32767 + (64'd1 << 29)) >> 30;
      if (v > 32767) begin
         v = 32767;
      end
      return 15'(v);
   endfunction

   function automatic qsine_type build_qsine();
      qsine_type rom;
      for (int j = 0; j <= QUARTER; j++) begin
         rom[j] = quarter_sine(j);
      end
      return rom;
   endfunction

   localparam qsine_type QSINE_ROM = build_qsine();

endpackage

@@ src/plucked_string_harmonic_voice.sv @@
// ----------------------------------------------------------------------------
// plucked_string_harmonic_voice: additive plucked-string voice
// Sixteen sine partials with loaded amplitude, phase step and decay; a
// pluck restarts the note and each tick renders one Q1.15 sample.
// ----------------------------------------------------------------------------
//  channel   handshake           payload
//  request   start / busy        req_mode, req_harmonic_index,
//                                req_start_amplitude, req_phase_step,
//                                req_decay_factor
//  response  rsp_valid strobe    rsp_sample, rsp_ringing
//  config    csr_we              csr_index, csr_wdata
//
//  A ringing tick walks all HARMONICS entries through a three-stage pipe,
//  then scales and presents the sample once the pipe has drained.
//  A pluck sweeps the voice RAM and holds busy until the pipe has drained.
//  Load, silence and a silent tick never raise busy; these items may follow each cycle.
//  Each item gives one result one cycle wide; the receiver cannot stall.
//  Synchronous reset; the harmonic tables read as zero until loaded.
// ----------------------------------------------------------------------------
module plucked_string_harmonic_voice
   import psh_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   output logic                  busy,
   input  logic [1:0]            req_mode,
   input  logic [3:0]            req_harmonic_index,
   input  logic [23:0]           req_start_amplitude,
   input  logic [23:0]           req_phase_step,
   input  logic [23:0]           req_decay_factor,
   output logic                  rsp_valid,
   output logic signed [15:0]    rsp_sample,
   output logic                  rsp_ringing,
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   cmd_type    cmd;
   status_type status;

   psh_ctrl u_ctrl (
      .clock    (clock),
      .reset    (reset),
      .start    (start),
      .req_mode (req_mode),
      .busy     (busy),
      .status   (status),
      .cmd      (cmd)
   );

   psh_dp u_dp (
      .clock               (clock),
      .reset               (reset),
      .cmd                 (cmd),
      .status              (status),
      .req_harmonic_index  (req_harmonic_index),
      .req_start_amplitude (req_start_amplitude),
      .req_phase_step      (req_phase_step),
      .req_decay_factor    (req_decay_factor),
      .csr_we              (csr_we),
      .csr_index           (csr_index),
      .csr_wdata           (csr_wdata),
      .rsp_valid           (rsp_valid),
      .rsp_sample          (rsp_sample),
      .rsp_ringing         (rsp_ringing)
   );

endmodule

@@ src/psh_ram.sv @@
// ----------------------------------------------------------------------------
// psh_ram: generic simple dual-port RAM
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
module psh_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                                   clock,
   input  logic                                   wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                       wr_data,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                       rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

@@ src/psh_ctrl.sv @@
// ----------------------------------------------------------------------------
// psh_ctrl: item sequencer for the plucked-string voice
// Decodes accepted items, walks the harmonics for ticks and plucks, waits
// for the datapath pipe to drain, then for a tick scales and presents the sample.
// ----------------------------------------------------------------------------
module psh_ctrl
   import psh_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       start,
   input  logic [1:0] req_mode,
   output logic       busy,
   input  status_type status,
   output cmd_type    cmd
);

   state_type             state_ff, state_in;
   logic [HARM_IDX_W-1:0] cnt_ff, cnt_in;
   logic                  op_tick_ff, op_tick_in;
   logic                  accept;

   assign busy   = (state_ff != ST_IDLE);
   assign accept = start && !busy;

   // state register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_IDLE;
         cnt_ff     <= '0;
         op_tick_ff <= 1'b0;
      end else begin
         state_ff   <= state_in;
         cnt_ff     <= cnt_in;
         op_tick_ff <= op_tick_in;
      end
   end

   // next state and commands
   always_comb begin
      state_in       = state_ff;
      cnt_in         = cnt_ff;
      op_tick_in     = op_tick_ff;
      cmd            = '0;
      cmd.addr       = cnt_ff;
      cmd.issue_tick = op_tick_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               unique case (mode_type'(req_mode))
                  MODE_TICK: begin
                     if (status.sounding) begin
                        cmd.tick_start = 1'b1;
                        op_tick_in     = 1'b1;
                        cnt_in         = '0;
                        state_in       = ST_ISSUE;
                     end else begin
                        cmd.idle_tick = 1'b1;
                     end
                  end
                  MODE_PLUCK: begin
                     cmd.pluck  = 1'b1;
                     op_tick_in = 1'b0;
                     cnt_in     = '0;
                     state_in   = ST_ISSUE;
                  end
                  MODE_SILENCE: cmd.silence = 1'b1;
                  MODE_LOAD:    cmd.load    = 1'b1;
                  default: ;
               endcase
            end
         end
         ST_ISSUE: begin
            cmd.issue = 1'b1;
            if (cnt_ff == LAST_IDX) begin
               state_in = ST_DRAIN;
            end else begin
               cnt_in = cnt_ff + 1'b1;
            end
         end
         ST_DRAIN: begin
            if (!status.pipe_busy) begin
               state_in = op_tick_ff ? ST_SCALE : ST_IDLE;
            end
         end
         ST_SCALE: begin
            cmd.scale = 1'b1;
            state_in  = ST_EMIT;
         end
         ST_EMIT: begin
            cmd.emit_tick = 1'b1;
            state_in      = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

`ifndef SYNTHESIS
   // a sweep never runs past the last harmonic
   a_cnt_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_ISSUE) |-> (cnt_ff <= LAST_IDX))
      else $error("harmonic counter out of range");

   // scaling only follows a tick sweep
   a_scale_tick: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SCALE) |-> op_tick_ff)
      else $error("scale without a tick");
`endif

endmodule

@@ src/psh_dp.sv @@
// ----------------------------------------------------------------------------
// psh_dp: datapath of the plucked-string voice
// Coefficient and voice RAMs, a three-stage harmonic pipe (decay, phase,
// sine lookup, envelope times sine, accumulate), gain scaling, the
// configuration registers and the result register.
// ----------------------------------------------------------------------------
module psh_dp
   import psh_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  cmd_type               cmd,
   output status_type            status,
   input  logic [3:0]            req_harmonic_index,
   input  logic [23:0]           req_start_amplitude,
   input  logic [23:0]           req_phase_step,
   input  logic [23:0]           req_decay_factor,
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata,
   output logic                  rsp_valid,
   output logic signed [15:0]    rsp_sample,
   output logic                  rsp_ringing
);

   localparam logic [24:0] GAIN_UNITY = 25'(1 << 24);
   localparam int OUT_W = SCALE_W - 24;
   localparam logic signed [OUT_W-1:0] SAT_HI = OUT_W'(32767);
   localparam logic signed [OUT_W-1:0] SAT_LO = -OUT_W'(32768);
   localparam logic [SINE_ADDR_BITS-2:0] QTR = (SINE_ADDR_BITS - 1)'(QUARTER);

   // configuration registers
   logic [24:0] attack_step_ff;
   logic [23:0] silence_level_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         attack_step_ff   <= 25'd16777;
         silence_level_ff <= 24'd168;
      end else if (csr_we) begin
         unique case (csr_index_type'(csr_index))
            CSR_ATTACK_STEP:   attack_step_ff   <= csr_wdata;
            CSR_SILENCE_LEVEL: silence_level_ff <= csr_wdata[23:0];
            default: ;
         endcase
      end
   end

   // coefficient store; entries never loaded read as zero
   logic                  idx_ok;
   logic                  coef_we;
   logic [HARM_IDX_W-1:0] coef_waddr;
   logic [COEF_W-1:0]     coef_wdata;
   logic [COEF_W-1:0]     coef_rd;
   logic [HARMONICS-1:0]  loaded_ff;

   assign idx_ok     = (int'(req_harmonic_index) < HARMONICS);
   assign coef_we    = cmd.load && idx_ok;
   assign coef_waddr = HARM_IDX_W'(req_harmonic_index);
   assign coef_wdata = {req_start_amplitude, PHASE_BITS'(req_phase_step), req_decay_factor};

   always_ff @(posedge clock) begin
      if (reset) begin
         loaded_ff <= '0;
      end else if (coef_we) begin
         loaded_ff[coef_waddr] <= 1'b1;
      end
   end

   psh_ram #(.WIDTH(COEF_W), .DEPTH(HARMONICS)) u_coef_ram (
      .clock   (clock),
      .wr_en   (coef_we),
      .wr_addr (coef_waddr),
      .wr_data (coef_wdata),
      .rd_addr (cmd.addr),
      .rd_data (coef_rd)
   );

   // voice store: envelope and phase, rewritten by every sweep
   logic                  p2_valid_ff;
   logic [HARM_IDX_W-1:0] p2_idx_ff;
   logic [23:0]           env_next_ff;
   logic [PHASE_BITS-1:0] phase_next_ff;
   logic [VOICE_W-1:0]    voice_rd;

   psh_ram #(.WIDTH(VOICE_W), .DEPTH(HARMONICS)) u_voice_ram (
      .clock   (clock),
      .wr_en   (p2_valid_ff),
      .wr_addr (p2_idx_ff),
      .wr_data ({env_next_ff, phase_next_ff}),
      .rd_addr (cmd.addr),
      .rd_data (voice_rd)
   );

   // stage 1 tags, aligned with RAM read data
   logic                  p1_valid_ff;
   logic                  p1_tick_ff;
   logic [HARM_IDX_W-1:0] p1_idx_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         p1_valid_ff <= 1'b0;
      end else begin
         p1_valid_ff <= cmd.issue;
      end
      p1_tick_ff <= cmd.issue_tick;
      p1_idx_ff  <= cmd.addr;
   end

   // stage 1: decay, phase advance, sine lookup
   logic                      ld1;
   logic [23:0]               amp1;
   logic [PHASE_BITS-1:0]     step1;
   logic [23:0]               decay1;
   logic [23:0]               env1;
   logic [PHASE_BITS-1:0]     phase1;
   logic [47:0]               env_decay;
   logic [SINE_ADDR_BITS-1:0] sidx;
   logic [SINE_ADDR_BITS-3:0] srem;
   logic [SINE_ADDR_BITS-2:0] qidx;
   logic [14:0]               smag;
   logic [15:0]               sine_in;
   logic [23:0]               env_next_in;
   logic [PHASE_BITS-1:0]     phase_next_in;

   always_comb begin
      ld1       = loaded_ff[p1_idx_ff];
      amp1      = ld1 ? coef_rd[COEF_W-1 -: 24] : '0;
      step1     = ld1 ? coef_rd[PHASE_BITS+23:24] : '0;
      decay1    = ld1 ? coef_rd[23:0] : '0;
      env1      = voice_rd[VOICE_W-1 -: 24];
      phase1    = voice_rd[PHASE_BITS-1:0];
      env_decay = env1 * decay1;
      // full-cycle index folded onto the quarter wave
      sidx      = phase1[PHASE_BITS-1 -: SINE_ADDR_BITS];
      srem      = sidx[SINE_ADDR_BITS-3:0];
      qidx      = sidx[SINE_ADDR_BITS-2] ? (QTR - {1'b0, srem}) : {1'b0, srem};
      smag      = QSINE_ROM[qidx];
      sine_in   = sidx[SINE_ADDR_BITS-1] ? (16'd0 - {1'b0, smag}) : {1'b0, smag};
      if (p1_tick_ff) begin
         env_next_in   = env_decay[47:24];
         phase_next_in = phase1 + step1;
      end else begin
         env_next_in   = amp1;
         phase_next_in = '0;
      end
   end

   logic                p2_tick_ff;
   logic [23:0]         env_cur_ff;
   logic signed [15:0]  sine_ff;
   logic [23:0]         fund_env_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         p2_valid_ff <= 1'b0;
      end else begin
         p2_valid_ff <= p1_valid_ff;
      end
      p2_tick_ff    <= p1_tick_ff;
      p2_idx_ff     <= p1_idx_ff;
      env_next_ff   <= env_next_in;
      phase_next_ff <= phase_next_in;
      env_cur_ff    <= env1;
      sine_ff       <= sine_in;
      if (p1_valid_ff && p1_tick_ff && (p1_idx_ff == '0)) begin
         fund_env_ff <= env_next_in;
      end
   end

   // stage 2: envelope times sine
   logic                     p3_valid_ff;
   logic signed [PROD_W-1:0] prod_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         p3_valid_ff <= 1'b0;
      end else begin
         p3_valid_ff <= p2_valid_ff && p2_tick_ff;
      end
      prod_ff <= $signed({1'b0, env_cur_ff}) * sine_ff;
   end

   // stage 3: accumulate, cleared when a tick starts
   logic signed [ACC_W-1:0] acc_ff;

   always_ff @(posedge clock) begin
      if (cmd.tick_start) begin
         acc_ff <= '0;
      end else if (p3_valid_ff) begin
         acc_ff <= acc_ff + ACC_W'(prod_ff);
      end
   end

   // attack gain and note state
   logic [24:0] gain_ff;
   logic        sounding_ff;
   logic [25:0] gain_sum;
   logic        ring_next;

   assign gain_sum  = {1'b0, gain_ff} + {1'b0, attack_step_ff};
   assign ring_next = (fund_env_ff >= silence_level_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         gain_ff     <= '0;
         sounding_ff <= 1'b0;
      end else begin
         if (cmd.pluck || cmd.silence) begin
            gain_ff <= '0;
         end else if (cmd.tick_start && (gain_ff < GAIN_UNITY)) begin
            gain_ff <= (gain_sum > {1'b0, GAIN_UNITY}) ? GAIN_UNITY : gain_sum[24:0];
         end
         if (cmd.pluck) begin
            sounding_ff <= 1'b1;
         end else if (cmd.silence) begin
            sounding_ff <= 1'b0;
         end else if (cmd.emit_tick) begin
            sounding_ff <= ring_next;
         end
      end
   end

   // gain scaling: floor(floor(acc / 2^24) * gain / 2^24)
   logic signed [ACC_W-25:0]  acc_hi;
   logic signed [SCALE_W-1:0] scaled_ff;
   logic signed [OUT_W-1:0]   out_full;
   logic signed [15:0]        out_sat;

   assign acc_hi = acc_ff[ACC_W-1:24];

   always_ff @(posedge clock) begin
      if (cmd.scale) begin
         scaled_ff <= acc_hi * $signed({1'b0, gain_ff});
      end
   end

   always_comb begin
      out_full = scaled_ff[SCALE_W-1:24];
      if (out_full > SAT_HI) begin
         out_sat = 16'sh7FFF;
      end else if (out_full < SAT_LO) begin
         out_sat = -16'sh8000;
      end else begin
         out_sat = out_full[15:0];
      end
   end

   // result register
   logic               rsp_valid_ff;
   logic signed [15:0] rsp_sample_ff;
   logic               rsp_ringing_ff;
   logic               emit_plain;

   assign emit_plain = cmd.load || cmd.pluck || cmd.silence || cmd.idle_tick;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= emit_plain || cmd.emit_tick;
      end
      if (cmd.emit_tick) begin
         rsp_sample_ff  <= out_sat;
         rsp_ringing_ff <= ring_next;
      end else begin
         rsp_sample_ff  <= '0;
         rsp_ringing_ff <= cmd.pluck ? 1'b1 : (cmd.silence ? 1'b0 : sounding_ff);
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_sample  = rsp_sample_ff;
   assign rsp_ringing = rsp_ringing_ff;

   assign status.sounding  = sounding_ff;
   assign status.pipe_busy = p1_valid_ff || p2_valid_ff || p3_valid_ff;

`ifndef SYNTHESIS
   // write-back never lands on the harmonic being read in the same cycle
   a_no_rw_clash: assert property (@(posedge clock) disable iff (reset)
      (p2_valid_ff && cmd.issue) |-> (p2_idx_ff != cmd.addr))
      else $error("voice RAM read/write collision");

   // the sample is taken only after the pipe is empty
   a_emit_drained: assert property (@(posedge clock) disable iff (reset)
      (cmd.scale || cmd.emit_tick) |-> !(p1_valid_ff || p2_valid_ff || p3_valid_ff))
      else $error("sample taken with pipe busy");

   // attack gain saturates at unity
   a_gain_max: assert property (@(posedge clock) disable iff (reset)
      gain_ff <= GAIN_UNITY)
      else $error("attack gain above unity");
`endif

endmodule
